[sv/ffha_pkg.sv]
// Shared types and codes for the first-fit heap allocator.
// Has no dependencies; the allocator top level imports it.
package ffha_pkg;

    localparam int OPCODE_W = 1;
    localparam int UNITS_W  = 12;
    localparam int STATUS_W = 2;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [UNITS_W-1:0]  t_units;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_opcode OP_ALLOC = 1'b0;
    localparam t_opcode OP_FREE  = 1'b1;

    localparam t_status ST_DONE     = 2'd0;
    localparam t_status ST_OOM      = 2'd1;
    localparam t_status ST_BAD_ADDR = 2'd2;

endpackage

[sv/ffha_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// The read data holds its value in cycles without a read. No dependencies.
module ffha_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/first_fit_heap_allocator_unit.sv]
// A request walks the free list, reading one header RAM entry per cycle, and then writes the
// headers it changes; a free whose address is out of range or names the head, or an allocate on
// an empty list, goes straight to the response state. Throughput: one request at a time;
// o_in_ready returns the cycle after the result register loads, which waits while it is full.
// Reset: synchronous; after reset the sequencer writes header zero and then goes idle.
// Top level of the first-fit heap allocator; uses ffha_pkg and ffha_ram.
module first_fit_heap_allocator_unit #(
    parameter int HEAP_UNITS   = 4096,
    parameter int HEADER_UNITS = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ffha_pkg::t_opcode i_opcode,
    input  ffha_pkg::t_units  i_request_units,
    input  ffha_pkg::t_units  i_block_addr,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ffha_pkg::t_status o_status,
    output ffha_pkg::t_units  o_alloc_addr
);

    import ffha_pkg::*;

    // IW indexes the header RAMs. AW also holds the null link, which equals HEAP_UNITS.
    // CW is wide enough that no address, size and request sum wraps.
    localparam int IW = $clog2(HEAP_UNITS);
    localparam int AW = IW + 1;
    localparam int CW = ((AW > UNITS_W) ? AW : UNITS_W) + 2;

    localparam logic [AW-1:0] NIL       = AW'(HEAP_UNITS);
    localparam logic [AW-1:0] STEP_MAX  = AW'(HEAP_UNITS);
    localparam logic [AW-1:0] INIT_SIZE = AW'(HEAP_UNITS - HEADER_UNITS);
    localparam logic [CW-1:0] HEAP_C    = CW'(HEAP_UNITS);
    localparam logic [CW-1:0] HDR_C     = CW'(HEADER_UNITS);
    localparam logic [CW-1:0] HDR2_C    = CW'(2 * HEADER_UNITS);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ACHK   = 4'd2;
    localparam logic [3:0] S_AW1    = 4'd3;
    localparam logic [3:0] S_AW2    = 4'd4;
    localparam logic [3:0] S_AW3    = 4'd5;
    localparam logic [3:0] S_FEMPTY = 4'd6;
    localparam logic [3:0] S_FLH    = 4'd7;
    localparam logic [3:0] S_FLH2   = 4'd8;
    localparam logic [3:0] S_FWALK  = 4'd9;
    localparam logic [3:0] S_FH     = 4'd10;
    localparam logic [3:0] S_FW1    = 4'd11;
    localparam logic [3:0] S_FW2    = 4'd12;
    localparam logic [3:0] S_RESP   = 4'd13;

    // Control registers.
    logic [3:0]    r_state,     n_state;
    logic [AW-1:0] r_head,      n_head;
    logic          r_out_valid, n_out_valid;

    // Working registers of the current request.
    logic [AW-1:0] r_cur,       n_cur;
    logic [AW-1:0] r_prev,      n_prev;
    logic [AW-1:0] r_prev_size, n_prev_size;
    logic [AW-1:0] r_h,         n_h;
    logic [AW-1:0] r_h_size,    n_h_size;
    logic [AW-1:0] r_rest,      n_rest;
    logic [AW-1:0] r_cnt,       n_cnt;
    t_units        r_req,       n_req;
    logic          r_split,     n_split;
    logic          r_prev_adj,  n_prev_adj;
    logic          r_next_adj,  n_next_adj;
    t_status       r_res_status, n_res_status;
    t_units        r_res_addr,   n_res_addr;
    t_status       r_out_status, n_out_status;
    t_units        r_out_addr,   n_out_addr;

    // Header RAM controls. Size and link RAMs share both addresses.
    logic          w_re;
    logic [IW-1:0] w_raddr;
    logic [IW-1:0] w_waddr;
    logic          w_we_size;
    logic          w_we_link;
    logic [AW-1:0] w_wsize;
    logic [AW-1:0] w_wlink;
    logic [AW-1:0] w_rd_size;
    logic [AW-1:0] w_rd_link;

    // Widened operands for the address and size arithmetic.
    logic [CW-1:0] w_rd_size_c;
    logic [CW-1:0] w_req_c;
    logic [CW-1:0] w_cur_c;
    logic [CW-1:0] w_h_c;
    logic [CW-1:0] w_addr_c;
    logic [CW-1:0] w_rest_c;
    logic [AW-1:0] w_h_in;
    logic [AW-1:0] w_cnt_inc;

    assign w_rd_size_c = CW'(w_rd_size);
    assign w_req_c     = CW'(r_req);
    assign w_cur_c     = CW'(r_cur);
    assign w_h_c       = CW'(r_h);
    assign w_addr_c    = CW'(i_block_addr);
    assign w_rest_c    = w_cur_c + HDR_C + w_req_c;
    assign w_h_in      = AW'(w_addr_c - HDR_C);
    assign w_cnt_inc   = r_cnt + AW'(1);

    ffha_ram #(
        .WIDTH (AW),
        .DEPTH (HEAP_UNITS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_size),
        .i_waddr (w_waddr),
        .i_wdata (w_wsize),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_size)
    );

    ffha_ram #(
        .WIDTH (AW),
        .DEPTH (HEAP_UNITS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_link),
        .i_waddr (w_waddr),
        .i_wdata (w_wlink),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_link)
    );

    // The sequencer reads one header per cycle and writes at most one header per cycle.
    // Reads and writes never touch the same entry in one cycle, and since the RAM read data
    // holds between reads, the last header read stays visible to the write states after it.
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_out_valid  = r_out_valid;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_prev_size  = r_prev_size;
        n_h          = r_h;
        n_h_size     = r_h_size;
        n_rest       = r_rest;
        n_cnt        = r_cnt;
        n_req        = r_req;
        n_split      = r_split;
        n_prev_adj   = r_prev_adj;
        n_next_adj   = r_next_adj;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;

        w_re      = 1'b0;
        w_raddr   = '0;
        w_waddr   = '0;
        w_we_size = 1'b0;
        w_we_link = 1'b0;
        w_wsize   = '0;
        w_wlink   = NIL;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                // Header zero describes the whole heap as one free block.
                w_waddr   = '0;
                w_we_size = 1'b1;
                w_we_link = 1'b1;
                w_wsize   = INIT_SIZE;
                w_wlink   = NIL;
                n_state   = S_IDLE;
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_req      = i_request_units;
                    n_res_addr = '0;
                    n_cnt      = '0;
                    if (i_opcode == OP_ALLOC) begin
                        if (r_head < NIL) begin
                            w_re    = 1'b1;
                            w_raddr = r_head[IW-1:0];
                            n_cur   = r_head;
                            n_prev  = NIL;
                            n_state = S_ACHK;
                        end else begin
                            n_res_status = ST_OOM;
                            n_state      = S_RESP;
                        end
                    end else if (w_addr_c < HDR_C || w_addr_c >= HEAP_C) begin
                        n_res_status = ST_BAD_ADDR;
                        n_state      = S_RESP;
                    end else begin
                        n_h = w_h_in;
                        if (!(r_head < NIL)) begin
                            n_state = S_FEMPTY;
                        end else if (w_h_in == r_head) begin
                            n_res_status = ST_BAD_ADDR;
                            n_state      = S_RESP;
                        end else if (w_h_in < r_head) begin
                            w_re    = 1'b1;
                            w_raddr = w_h_in[IW-1:0];
                            n_state = S_FLH;
                        end else begin
                            w_re    = 1'b1;
                            w_raddr = r_head[IW-1:0];
                            n_cur   = r_head;
                            n_state = S_FWALK;
                        end
                    end
                end
            end

            S_ACHK: begin
                // The header of r_cur is on the RAM outputs; r_cnt counts the hops so far.
                if (w_rd_size_c >= w_req_c) begin
                    n_state = S_AW1;
                end else if (r_cnt == STEP_MAX || !(w_rd_link < NIL)) begin
                    n_res_status = ST_OOM;
                    n_state      = S_RESP;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_rd_link[IW-1:0];
                    n_prev  = r_cur;
                    n_cur   = w_rd_link;
                    n_cnt   = w_cnt_inc;
                end
            end

            S_AW1: begin
                // Split only when the remainder holds more than a header and lies inside the heap.
                n_rest = AW'(w_rest_c);
                if ((w_rd_size_c > w_req_c + HDR_C) && (w_rest_c < HEAP_C)) begin
                    n_split   = 1'b1;
                    w_waddr   = w_rest_c[IW-1:0];
                    w_we_size = 1'b1;
                    w_we_link = 1'b1;
                    w_wsize   = AW'(w_rd_size_c - w_req_c - HDR_C);
                    w_wlink   = w_rd_link;
                end else begin
                    n_split = 1'b0;
                end
                n_state = S_AW2;
            end

            S_AW2: begin
                w_waddr   = r_cur[IW-1:0];
                w_we_link = 1'b1;
                w_wlink   = NIL;
                w_we_size = r_split;
                w_wsize   = AW'(w_req_c);
                n_state   = S_AW3;
            end

            S_AW3: begin
                // Unlink the block: its predecessor, or the head, takes the successor.
                if (r_prev < NIL) begin
                    w_waddr   = r_prev[IW-1:0];
                    w_we_link = 1'b1;
                    w_wlink   = r_split ? r_rest : w_rd_link;
                end else begin
                    n_head = r_split ? r_rest : w_rd_link;
                end
                n_res_status = ST_DONE;
                n_res_addr   = UNITS_W'(w_cur_c + HDR_C);
                n_state      = S_RESP;
            end

            S_FEMPTY: begin
                w_waddr      = r_h[IW-1:0];
                w_we_link    = 1'b1;
                w_wlink      = NIL;
                n_head       = r_h;
                n_res_status = ST_DONE;
                n_state      = S_RESP;
            end

            S_FLH: begin
                // Freed block lies below the head: merge with the head when they touch.
                n_h_size = w_rd_size;
                if (w_h_c + HDR_C + w_rd_size_c == CW'(r_head)) begin
                    w_re    = 1'b1;
                    w_raddr = r_head[IW-1:0];
                    n_state = S_FLH2;
                end else begin
                    w_waddr      = r_h[IW-1:0];
                    w_we_link    = 1'b1;
                    w_wlink      = r_head;
                    n_head       = r_h;
                    n_res_status = ST_DONE;
                    n_state      = S_RESP;
                end
            end

            S_FLH2: begin
                w_waddr      = r_h[IW-1:0];
                w_we_size    = 1'b1;
                w_we_link    = 1'b1;
                w_wsize      = AW'(CW'(r_h_size) + HDR_C + w_rd_size_c);
                w_wlink      = w_rd_link;
                n_head       = r_h;
                n_res_status = ST_DONE;
                n_state      = S_RESP;
            end

            S_FWALK: begin
                // The header of r_cur is on the RAM outputs and becomes the predecessor.
                // r_cnt counts the headers read; the walk allows one more than the hop limit.
                n_prev      = r_cur;
                n_prev_size = w_rd_size;
                n_cur       = w_rd_link;
                n_cnt       = w_cnt_inc;
                if (w_rd_link < NIL && w_rd_link < r_h && w_cnt_inc <= STEP_MAX) begin
                    w_re    = 1'b1;
                    w_raddr = w_rd_link[IW-1:0];
                end else if (w_rd_link == r_h) begin
                    n_res_status = ST_BAD_ADDR;
                    n_state      = S_RESP;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_h[IW-1:0];
                    n_state = S_FH;
                end
            end

            S_FH: begin
                // Decide both merges; fetch the next free header when it touches the block.
                n_h_size   = w_rd_size;
                n_prev_adj = (CW'(r_prev) + HDR_C + CW'(r_prev_size) == w_h_c);
                n_next_adj = (r_cur < NIL) && (w_h_c + HDR_C + w_rd_size_c == w_cur_c);
                if ((r_cur < NIL) && (w_h_c + HDR_C + w_rd_size_c == w_cur_c)) begin
                    w_re    = 1'b1;
                    w_raddr = r_cur[IW-1:0];
                end
                n_state = S_FW1;
            end

            S_FW1: begin
                // When the next block merges, its header is on the RAM outputs.
                n_res_status = ST_DONE;
                if (r_prev_adj && r_next_adj) begin
                    w_waddr   = r_prev[IW-1:0];
                    w_we_size = 1'b1;
                    w_we_link = 1'b1;
                    w_wsize   = AW'(CW'(r_prev_size) + HDR2_C + CW'(r_h_size) + w_rd_size_c);
                    w_wlink   = w_rd_link;
                    n_state   = S_RESP;
                end else if (r_prev_adj) begin
                    w_waddr   = r_prev[IW-1:0];
                    w_we_size = 1'b1;
                    w_wsize   = AW'(CW'(r_prev_size) + HDR_C + CW'(r_h_size));
                    n_state   = S_RESP;
                end else if (r_next_adj) begin
                    w_waddr   = r_h[IW-1:0];
                    w_we_size = 1'b1;
                    w_we_link = 1'b1;
                    w_wsize   = AW'(CW'(r_h_size) + HDR_C + w_rd_size_c);
                    w_wlink   = w_rd_link;
                    n_state   = S_FW2;
                end else begin
                    w_waddr   = r_h[IW-1:0];
                    w_we_link = 1'b1;
                    w_wlink   = (r_cur < NIL) ? r_cur : NIL;
                    n_state   = S_FW2;
                end
            end

            S_FW2: begin
                w_waddr      = r_prev[IW-1:0];
                w_we_link    = 1'b1;
                w_wlink      = r_h;
                n_res_status = ST_DONE;
                n_state      = S_RESP;
            end

            S_RESP: begin
                // Hand the result to the output register once it is free or being emptied.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_addr   = r_res_addr;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_prev_size  <= n_prev_size;
        r_h          <= n_h;
        r_h_size     <= n_h_size;
        r_rest       <= n_rest;
        r_cnt        <= n_cnt;
        r_req        <= n_req;
        r_split      <= n_split;
        r_prev_adj   <= n_prev_adj;
        r_next_adj   <= n_next_adj;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_alloc_addr = r_out_addr;

endmodule
